[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(name, clock, reset_n, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(name, clock, reset_n, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/wanm_pkg.sv]
`default_nettype none

package wanm_pkg;

    // Alphabet and letter coding.
    localparam int NBINS = 26;
    localparam int LW    = 5;

    // Window storage and counter widths.
    localparam int MAX_PATTERN = 1024;
    localparam int CW          = $clog2(MAX_PATTERN + 1);
    localparam int RAW         = $clog2(MAX_PATTERN);
    localparam int NCW         = $clog2(NBINS + 1);

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FPW        = $clog2(FIFO_DEPTH);
    localparam int FCW        = $clog2(FIFO_DEPTH + 1) + 1;

    // Request operation codes.
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_PATTERN = 2'd1;
    localparam logic [1:0] OP_TEXT    = 2'd2;

    // Control that travels with a request down the pipeline.
    typedef struct packed {
        logic          clr;
        logic          pat;
        logic          pat_ok;
        logic          txt;
        logic          inc;
        logic          dec_pos;
        logic          check;
        logic          gt;
        logic          last;
        logic [LW-1:0] letter;
    } stage_t;

    // One histogram memory entry: pattern tally and text arrivals.
    typedef struct packed {
        logic [CW-1:0] p;
        logic [CW-1:0] inc;
    } hent_t;

    // How one bin of the window compares with the pattern.
    typedef struct packed {
        logic up;
        logic down;
        logic same;
    } bin_cls_t;

    function automatic bin_cls_t bin_class(input logic [CW-1:0] w, input logic [CW-1:0] p);
        bin_cls_t r;
        r.same = (w == p);
        r.up   = ((CW+1)'(w) == (CW+1)'(p) + (CW+1)'(1));
        r.down = ((CW+1)'(p) == (CW+1)'(w) + (CW+1)'(1));
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/window_anagram_near_match.sv]
// Channel   | Dir | Handshake            | Payload
// request   | in  | in_valid / in_stall  | op[1:0], letter[4:0], last
// result    | out | out_valid / out_stall| match
//
// One request is taken every cycle while in_stall is low; a result passes stages B
// and C and is then written into a four-entry queue, where it waits until taken.
// The rate is set by the histogram memories: one read-modify-write per request.
// Reset clears all control at once; histogram entries carry valid bits, so no
// clearing pass is needed and the block is ready straight after reset.
// in_stall rises only when queued results plus results still in the pipeline
// would fill the queue.
`default_nettype none

module window_anagram_near_match
    import wanm_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [1:0]    op,
    input  wire logic [LW-1:0] letter,
    input  wire logic          last,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic               match
);

`include "assert_macros.svh"

    // ------------------------------------------------------------------
    // Stage A: request decode, window position and ring write.
    // ------------------------------------------------------------------
    logic            acc;
    logic            letter_ok;
    logic            has_len;
    logic [CW-1:0]   tp_after;
    logic [CW-1:0]   len_reg, len_next;
    logic [CW-1:0]   tp_reg, tp_next;
    logic [RAW-1:0]  wr_reg, wr_next;
    logic            ring_we;
    logic            a_live;
    stage_t          a_ctl;

    assign acc       = in_valid && !in_stall;
    assign letter_ok = (letter < LW'(NBINS));
    assign has_len   = (len_reg != '0);
    assign tp_after  = (tp_reg <= len_reg) ? tp_reg + CW'(1) : tp_reg;

    // Decode the request and work out the next window position.
    always_comb
    begin
        len_next     = len_reg;
        tp_next      = tp_reg;
        wr_next      = wr_reg;
        ring_we      = 1'b0;
        a_live       = 1'b0;
        a_ctl        = '0;
        a_ctl.letter = letter;
        case (op)
            OP_CLEAR:
            begin
                a_live    = 1'b1;
                a_ctl.clr = 1'b1;
                len_next  = '0;
                tp_next   = '0;
                wr_next   = '0;
            end
            OP_PATTERN:
            begin
                a_live    = 1'b1;
                a_ctl.pat = 1'b1;
                tp_next   = '0;
                wr_next   = '0;
                if (letter_ok && (len_reg < CW'(MAX_PATTERN)))
                begin
                    len_next     = len_reg + CW'(1);
                    a_ctl.pat_ok = 1'b1;
                end
            end
            OP_TEXT:
            begin
                a_live        = 1'b1;
                a_ctl.txt     = 1'b1;
                a_ctl.inc     = has_len && letter_ok;
                a_ctl.dec_pos = has_len && (tp_reg >= len_reg);
                a_ctl.check   = (tp_after >= len_reg);
                a_ctl.gt      = (tp_after > len_reg);
                a_ctl.last    = last;
                ring_we       = has_len;
                tp_next       = tp_after;
                if (has_len)
                begin
                    wr_next = ((CW'(wr_reg) + CW'(1)) >= len_reg) ? '0 : wr_reg + RAW'(1);
                end
                if (last)
                begin
                    tp_next = '0;
                    wr_next = '0;
                end
            end
            default:
            begin
                a_live = 1'b0;
            end
        endcase
    end

    // Window position registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            tp_reg  <= '0;
            wr_reg  <= '0;
        end
        else if (acc)
        begin
            len_reg <= len_next;
            tp_reg  <= tp_next;
            wr_reg  <= wr_next;
        end
    end

    // Letter ring: the entry at the write pointer is the letter that leaves.
    logic [LW-1:0] ring_mem [MAX_PATTERN];
    logic [LW-1:0] ring_rd_reg;

    always_ff @(posedge clk)
    begin
        if (acc && ring_we)
        begin
            ring_mem[wr_reg] <= letter;
        end
        ring_rd_reg <= ring_mem[wr_reg];
    end

    // ------------------------------------------------------------------
    // Stage B: departing letter known, histogram reads issued.
    // ------------------------------------------------------------------
    logic          b_valid_reg;
    stage_t        b_reg;
    logic          old_ok;
    logic          b_dec;
    logic [LW-1:0] n_addr;
    logic [LW-1:0] o_addr;

    assign old_ok = (ring_rd_reg < LW'(NBINS));
    assign b_dec  = b_reg.dec_pos && old_ok;
    assign n_addr = (b_reg.letter < LW'(NBINS)) ? b_reg.letter : '0;
    assign o_addr = old_ok ? ring_rd_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= acc && a_live;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg <= a_ctl;
    end

    // Histogram memories: pattern tally with arrivals, and departures.
    hent_t         h_mem [NBINS];
    logic [CW-1:0] d_mem [NBINS];
    hent_t         h_rd0_reg, h_rd1_reg;
    logic [CW-1:0] d_rd0_reg, d_rd1_reg;
    logic          h_we;
    logic [LW-1:0] h_waddr;
    hent_t         h_wdata;
    logic          d_we;
    logic [LW-1:0] d_waddr;
    logic [CW-1:0] d_wdata;

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            h_mem[h_waddr] <= h_wdata;
        end
        if (d_we)
        begin
            d_mem[d_waddr] <= d_wdata;
        end
        h_rd0_reg <= h_mem[n_addr];
        h_rd1_reg <= h_mem[o_addr];
        d_rd0_reg <= d_mem[n_addr];
        d_rd1_reg <= d_mem[o_addr];
    end

    // ------------------------------------------------------------------
    // Stage C: read-modify-write of two bins and the match counters.
    // ------------------------------------------------------------------
    logic          c_valid_reg;
    stage_t        c_reg;
    logic          c_dec_reg;
    logic [LW-1:0] c_n_reg;
    logic [LW-1:0] c_o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg     <= b_reg;
        c_dec_reg <= b_dec;
        c_n_reg   <= n_addr;
        c_o_reg   <= o_addr;
    end

    // Last writes, forwarded to the reads issued in the same cycle.
    logic          hw_v_reg;
    logic [LW-1:0] hw_addr_reg;
    hent_t         hw_data_reg;
    logic          dw_v_reg;
    logic [LW-1:0] dw_addr_reg;
    logic [CW-1:0] dw_data_reg;

    // Per-bin valid bits and the running tallies.
    logic [NBINS-1:0] pv_reg, pv_next;
    logic [NBINS-1:0] iv_reg, iv_next;
    logic [NBINS-1:0] dv_reg, dv_next;
    logic [NCW-1:0]   pz_reg, pz_next;
    logic [NCW-1:0]   po_reg, po_next;
    logic [NCW-1:0]   same_reg, same_next;
    logic [NCW-1:0]   up_reg, up_next;
    logic [NCW-1:0]   down_reg, down_next;
    logic             exact_seen_reg, exact_seen_next;
    logic             near_seen_reg, near_seen_next;

    hent_t          h0, h1;
    logic [CW-1:0]  d0, d1;
    logic [CW-1:0]  p_n, inc_n, dec_n, w_n;
    logic [CW-1:0]  p_o, inc_o, dec_o, w_o;
    bin_cls_t       cls_nb, cls_na, cls_ob, cls_oa;
    logic           txt_live, inc_live, dec_live;
    logic           same_bin, n_chg, o_chg;
    logic           clear_text;
    logic [NCW-1:0] same_t, up_t, down_t;
    logic           exact_hit, near_hit;
    logic           ex_t, ne_t;
    logic           push;
    logic           push_match;

    // Pick memory data or the write just made, then apply the valid bits.
    always_comb
    begin
        h0    = (hw_v_reg && (hw_addr_reg == c_n_reg)) ? hw_data_reg : h_rd0_reg;
        h1    = (hw_v_reg && (hw_addr_reg == c_o_reg)) ? hw_data_reg : h_rd1_reg;
        d0    = (dw_v_reg && (dw_addr_reg == c_n_reg)) ? dw_data_reg : d_rd0_reg;
        d1    = (dw_v_reg && (dw_addr_reg == c_o_reg)) ? dw_data_reg : d_rd1_reg;
        p_n   = pv_reg[c_n_reg] ? h0.p : '0;
        inc_n = iv_reg[c_n_reg] ? h0.inc : '0;
        dec_n = dv_reg[c_n_reg] ? d0 : '0;
        p_o   = pv_reg[c_o_reg] ? h1.p : '0;
        inc_o = iv_reg[c_o_reg] ? h1.inc : '0;
        dec_o = dv_reg[c_o_reg] ? d1 : '0;
        w_n   = inc_n - dec_n;
        w_o   = inc_o - dec_o;
    end

    // Classify the two touched bins before and after the update.
    assign txt_live = c_valid_reg && c_reg.txt;
    assign inc_live = txt_live && c_reg.inc;
    assign dec_live = txt_live && c_dec_reg;
    assign same_bin = inc_live && dec_live && (c_n_reg == c_o_reg);
    assign n_chg    = inc_live && !same_bin;
    assign o_chg    = dec_live && !same_bin;
    assign cls_nb   = bin_class(w_n, p_n);
    assign cls_na   = bin_class(w_n + CW'(1), p_n);
    assign cls_ob   = bin_class(w_o, p_o);
    assign cls_oa   = bin_class(w_o - CW'(1), p_o);

    assign same_t = same_reg + NCW'(n_chg & cls_na.same) + NCW'(o_chg & cls_oa.same)
                    - NCW'(n_chg & cls_nb.same) - NCW'(o_chg & cls_ob.same);
    assign up_t   = up_reg + NCW'(n_chg & cls_na.up) + NCW'(o_chg & cls_oa.up)
                    - NCW'(n_chg & cls_nb.up) - NCW'(o_chg & cls_ob.up);
    assign down_t = down_reg + NCW'(n_chg & cls_na.down) + NCW'(o_chg & cls_oa.down)
                    - NCW'(n_chg & cls_nb.down) - NCW'(o_chg & cls_ob.down);

    // Window checks and the result of a finished text string.
    assign exact_hit  = c_reg.check && (same_t == NCW'(NBINS));
    assign near_hit   = c_reg.check && (up_t == NCW'(1)) && (down_t == NCW'(1))
                        && (same_t == NCW'(NBINS - 2));
    assign ex_t       = exact_seen_reg || exact_hit;
    assign ne_t       = near_seen_reg || near_hit;
    assign push       = txt_live && c_reg.last;
    assign push_match = ne_t || (ex_t && c_reg.gt);
    assign clear_text = c_valid_reg && (c_reg.clr || c_reg.pat || (c_reg.txt && c_reg.last));

    // Memory writes, valid bits and tally updates.
    always_comb
    begin
        h_we            = 1'b0;
        h_waddr         = c_n_reg;
        h_wdata         = '{p: p_n, inc: inc_n + CW'(1)};
        d_we            = dec_live;
        d_waddr         = c_o_reg;
        d_wdata         = dec_o + CW'(1);
        pv_next         = pv_reg;
        iv_next         = iv_reg;
        dv_next         = dv_reg;
        pz_next         = pz_reg;
        po_next         = po_reg;
        same_next       = same_reg;
        up_next         = up_reg;
        down_next       = down_reg;
        exact_seen_next = exact_seen_reg;
        near_seen_next  = near_seen_reg;

        if (c_valid_reg && c_reg.pat_ok)
        begin
            h_we             = 1'b1;
            h_wdata          = '{p: p_n + CW'(1), inc: '0};
            pv_next[c_n_reg] = 1'b1;
            pz_next          = pz_reg - NCW'(p_n == '0);
            po_next          = po_reg + NCW'(p_n == '0) - NCW'(p_n == CW'(1));
        end
        if (inc_live)
        begin
            h_we             = 1'b1;
            iv_next[c_n_reg] = 1'b1;
        end
        if (dec_live)
        begin
            dv_next[c_o_reg] = 1'b1;
        end
        if (txt_live)
        begin
            same_next       = same_t;
            up_next         = up_t;
            down_next       = down_t;
            exact_seen_next = ex_t;
            near_seen_next  = ne_t;
        end
        if (c_valid_reg && c_reg.clr)
        begin
            pv_next = '0;
            pz_next = NCW'(NBINS);
            po_next = '0;
        end
        if (clear_text)
        begin
            iv_next         = '0;
            dv_next         = '0;
            same_next       = pz_next;
            down_next       = po_next;
            up_next         = '0;
            exact_seen_next = 1'b0;
            near_seen_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg         <= '0;
            iv_reg         <= '0;
            dv_reg         <= '0;
            pz_reg         <= NCW'(NBINS);
            po_reg         <= '0;
            same_reg       <= NCW'(NBINS);
            up_reg         <= '0;
            down_reg       <= '0;
            exact_seen_reg <= 1'b0;
            near_seen_reg  <= 1'b0;
            hw_v_reg       <= 1'b0;
            dw_v_reg       <= 1'b0;
        end
        else
        begin
            pv_reg         <= pv_next;
            iv_reg         <= iv_next;
            dv_reg         <= dv_next;
            pz_reg         <= pz_next;
            po_reg         <= po_next;
            same_reg       <= same_next;
            up_reg         <= up_next;
            down_reg       <= down_next;
            exact_seen_reg <= exact_seen_next;
            near_seen_reg  <= near_seen_next;
            hw_v_reg       <= h_we;
            dw_v_reg       <= d_we;
        end
    end

    always_ff @(posedge clk)
    begin
        hw_addr_reg <= h_waddr;
        hw_data_reg <= h_wdata;
        dw_addr_reg <= d_waddr;
        dw_data_reg <= d_wdata;
    end

    // ------------------------------------------------------------------
    // Result queue.
    // ------------------------------------------------------------------
    logic           q_mem_reg [FIFO_DEPTH];
    logic [FPW-1:0] q_wp_reg, q_rp_reg;
    logic [FCW-1:0] q_cnt_reg;
    logic           pop;
    logic           b_res;
    logic           c_res;

    assign pop       = out_valid && !out_stall;
    assign out_valid = (q_cnt_reg != '0);
    assign match     = q_mem_reg[q_rp_reg];
    assign b_res     = b_valid_reg && b_reg.txt && b_reg.last;
    assign c_res     = push;
    assign in_stall  = ((q_cnt_reg + FCW'(b_res) + FCW'(c_res)) >= FCW'(FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg  <= '0;
            q_rp_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                q_wp_reg <= q_wp_reg + FPW'(1);
            end
            if (pop)
            begin
                q_rp_reg <= q_rp_reg + FPW'(1);
            end
            q_cnt_reg <= q_cnt_reg + FCW'(push) - FCW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[q_wp_reg] <= push_match;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_queue_room, clk, rst_n, push, (q_cnt_reg < FCW'(FIFO_DEPTH)) || pop)
    `ASSERT_IMPL(a_bin_total, clk, rst_n, 1'b1,
        (7'(same_reg) + 7'(up_reg) + 7'(down_reg)) <= 7'(NBINS))
    `ASSERT_NEXT(a_flags_cleared, clk, rst_n, push, !exact_seen_reg && !near_seen_reg)
    `ASSERT_IMPL(a_leaving_bin_nonempty, clk, rst_n, o_chg, w_o != '0)
    `ASSERT_IMPL(a_pos_bound, clk, rst_n, 1'b1,
        (CW+1)'(tp_reg) <= (CW+1)'(len_reg) + (CW+1)'(1))

endmodule

`default_nettype wire

[dv/window_anagram_near_match_tb.sv]
`default_nettype none

module window_anagram_near_match_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wanm_pkg::*;

    // The one op code the block has no name for; it must be ignored.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Requests near the end of the queue are sent with no random gaps on either side.
    localparam int CALM_TAIL = 150;
    localparam int RANDOM_REQUESTS = 1100;

    typedef struct packed {
        logic [1:0]    op;
        logic [LW-1:0] letter;
        logic          last;
        logic          drain;
    } request_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [1:0]    op = OP_CLEAR;
    logic [LW-1:0] letter = '0;
    logic          last = 1'b0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic          match;

    window_anagram_near_match dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .letter    (letter),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .match     (match)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Requests waiting to be sent, and match flags waiting to come back.
    request_t request_q[$];
    bit       pending_matches[$];

    // Mirror of the block's pattern and sliding window.
    int unsigned   pat_tally[NBINS];
    int unsigned   win_tally[NBINS];
    logic [LW-1:0] window_letters[MAX_PATTERN];
    int unsigned   pat_len;
    int unsigned   text_pos;
    int unsigned   ring_ptr;
    bit            exact_hit;
    bit            near_hit;

    int       requests_taken = 0;
    int       results_checked = 0;
    int       matches_seen = 0;
    int       errors = 0;
    int       total_requests;
    int       gap_left = 0;
    int       stall_left = 0;
    int       tick = 0;
    request_t next_req;

    // Stimulus generator state: kept pattern letters and the current alphabet.
    int planned = 0;
    int pat_word[$];
    int alpha_lo = 0;
    int alpha_span = 2;
    bit hold_next = 1'b0;

    function automatic void restart_text();
        foreach (win_tally[b])
            win_tally[b] = 0;
        text_pos = 0;
        ring_ptr = 0;
        exact_hit = 1'b0;
        near_hit = 1'b0;
    endfunction

    // Compare the window histogram with the pattern and set the sticky flags.
    function automatic void score_window();
        int ups;
        int downs;
        int sames;
        ups = 0;
        downs = 0;
        sames = 0;
        for (int b = 0; b < NBINS; b++)
        begin
            if (win_tally[b] == pat_tally[b] + 1)
                ups++;
            else if (pat_tally[b] == win_tally[b] + 1)
                downs++;
            else if (pat_tally[b] == win_tally[b])
                sames++;
        end
        if (sames == NBINS)
            exact_hit = 1'b1;
        if (ups == 1 && downs == 1 && sames == NBINS - 2)
            near_hit = 1'b1;
    endfunction

    // Advance the mirror by one accepted request and queue any match it produces.
    function automatic void update_anagram_state(logic [1:0] o, logic [LW-1:0] l, logic lst);
        int unsigned   slot;
        logic [LW-1:0] old;
        case (o)
            OP_CLEAR:
            begin
                foreach (pat_tally[b])
                    pat_tally[b] = 0;
                pat_len = 0;
                restart_text();
            end
            OP_PATTERN:
            begin
                restart_text();
                if (l < NBINS && pat_len < MAX_PATTERN)
                begin
                    pat_tally[l]++;
                    pat_len++;
                end
            end
            OP_TEXT:
            begin
                if (pat_len > 0)
                begin
                    slot = (ring_ptr >= MAX_PATTERN) ? 0 : ring_ptr;
                    // Once the window is full, the oldest letter leaves its bin.
                    if (text_pos >= pat_len)
                    begin
                        old = window_letters[slot];
                        if (old < NBINS && win_tally[old] > 0)
                            win_tally[old]--;
                    end
                    window_letters[slot] = l;
                    if (l < NBINS)
                        win_tally[l]++;
                    slot++;
                    ring_ptr = (slot >= pat_len) ? 0 : slot;
                end
                if (text_pos <= pat_len)
                    text_pos++;
                if (text_pos >= pat_len)
                    score_window();
                if (lst)
                begin
                    pending_matches.push_back(near_hit || (exact_hit && text_pos > pat_len));
                    restart_text();
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic queue_req(logic [1:0] o, int l, bit lst);
        request_t r;
        r.op = o;
        r.letter = LW'(l);
        r.last = lst;
        r.drain = hold_next;
        hold_next = 1'b0;
        request_q.push_back(r);
        if (o != OP_UNUSED)
            planned++;
    endtask

    // Mostly letters of the current alphabet, now and then one outside a..z.
    function automatic int pick_letter();
        if ($urandom_range(0, 39) == 0)
            return int'($urandom_range(NBINS, 31));
        return alpha_lo + int'($urandom_range(0, alpha_span));
    endfunction

    task automatic add_pattern_letter(int l);
        queue_req(OP_PATTERN, l, 1'($urandom_range(0, 1)));
        if (l < NBINS && pat_word.size() < MAX_PATTERN)
            pat_word.push_back(l);
    endtask

    task automatic load_pattern(int len, bit fresh);
        if (fresh)
        begin
            queue_req(OP_CLEAR, int'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            pat_word.delete();
        end
        repeat (len)
            add_pattern_letter(pick_letter());
    endtask

    // One text string: a shuffled copy of the pattern, the same with one letter
    // changed, or random letters, with random letters around it.
    task automatic add_text();
        int body[$];
        int kind;
        int k;
        int j;
        int t;
        int n;
        body = pat_word;
        for (k = body.size() - 1; k > 0; k--)
        begin
            j = int'($urandom_range(0, k));
            t = body[k];
            body[k] = body[j];
            body[j] = t;
        end
        kind = int'($urandom_range(0, 9));
        if (kind >= 4 && kind <= 6 && body.size() > 0)
        begin
            k = int'($urandom_range(0, body.size() - 1));
            body[k] = (body[k] + 1 + int'($urandom_range(0, NBINS - 2))) % NBINS;
        end
        else if (kind >= 7)
        begin
            n = body.size() + int'($urandom_range(0, 3)) - 1;
            body.delete();
            repeat (n)
                body.push_back(pick_letter());
        end
        if ($urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 3))
                body.push_front(pick_letter());
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
                body.push_back(pick_letter());
        if (body.size() == 0)
            body.push_back(pick_letter());
        for (k = 0; k < body.size(); k++)
        begin
            // Occasional noise: an ignored op code, or a pattern letter that
            // breaks the text in the middle.
            if (k > 0 && $urandom_range(0, 59) == 0)
                queue_req(OP_UNUSED, int'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            if (k > 0 && $urandom_range(0, 99) == 0)
                add_pattern_letter(pick_letter());
            queue_req(OP_TEXT, body[k], k == body.size() - 1);
        end
    endtask

    task automatic build_stimulus();
        int base;
        int session;
        int pick;
        // Directed: empty pattern, ignored op code, dropped pattern letter,
        // exact windows with equal and longer text, near window, letters
        // outside a..z, short text, and a text broken by a pattern letter.
        queue_req(OP_TEXT, 0, 1'b1);
        queue_req(OP_UNUSED, 31, 1'b1);
        queue_req(OP_PATTERN, 0, 1'b1);
        queue_req(OP_PATTERN, 25, 1'b0);
        queue_req(OP_PATTERN, 30, 1'b0);
        queue_req(OP_TEXT, 25, 1'b0);
        queue_req(OP_TEXT, 0, 1'b1);
        queue_req(OP_TEXT, 3, 1'b0);
        queue_req(OP_TEXT, 25, 1'b0);
        queue_req(OP_TEXT, 0, 1'b1);
        queue_req(OP_TEXT, 0, 1'b0);
        queue_req(OP_TEXT, 0, 1'b1);
        queue_req(OP_TEXT, 31, 1'b0);
        queue_req(OP_TEXT, 26, 1'b1);
        queue_req(OP_TEXT, 31, 1'b0);
        queue_req(OP_TEXT, 0, 1'b0);
        queue_req(OP_TEXT, 25, 1'b1);
        queue_req(OP_TEXT, 25, 1'b1);
        queue_req(OP_TEXT, 0, 1'b0);
        queue_req(OP_PATTERN, 2, 1'b0);
        queue_req(OP_TEXT, 2, 1'b0);
        queue_req(OP_TEXT, 25, 1'b0);
        queue_req(OP_TEXT, 0, 1'b1);
        queue_req(OP_CLEAR, 31, 1'b1);
        queue_req(OP_TEXT, 31, 1'b1);

        // Random sessions: a new or extended pattern, then a few texts.
        base = planned;
        session = 0;
        while (planned - base < RANDOM_REQUESTS)
        begin
            hold_next = (session % 12 == 1);
            if ($urandom_range(0, 7) == 0)
                alpha_span = NBINS - 1;
            else
                alpha_span = int'($urandom_range(0, 3));
            alpha_lo = int'($urandom_range(0, NBINS - 1 - alpha_span));
            pick = int'($urandom_range(0, 19));
            if (pick == 0)
                load_pattern(0, 1'b1);
            else if (pick < 14)
                load_pattern(int'($urandom_range(1, 6)), 1'b1);
            else if (pick < 17)
                load_pattern(int'($urandom_range(7, 40)), 1'b1);
            else
                load_pattern(int'($urandom_range(1, 3)), 1'b0);
            repeat ($urandom_range(1, 4))
                add_text();
            session++;
        end
    endtask

    always @(posedge clk)
        tick <= tick + 1;

    // Request driver.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                update_anagram_state(op, letter, last);
                requests_taken++;
            end
            if (in_valid && in_stall)
            begin
                // Held: the payload stays put until the block takes it.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (request_q.size() == 0 ||
                     (request_q[0].drain && pending_matches.size() != 0))
            begin
                in_valid <= 1'b0;
            end
            else if (request_q.size() >= CALM_TAIL && tick[6:5] != 2'b11 &&
                     $urandom_range(0, 9) == 0)
            begin
                gap_left = int'($urandom_range(0, 17));
                in_valid <= 1'b0;
            end
            else
            begin
                next_req = request_q.pop_front();
                in_valid <= 1'b1;
                op <= next_req.op;
                letter <= next_req.letter;
                last <= next_req.last;
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_matches.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: result match=%0b arrived with none expected", match);
                end
                else
                begin
                    results_checked++;
                    if (match === 1'b1)
                        matches_seen++;
                    if (match !== pending_matches[0])
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: result %0d match expected %0b, got %0b",
                                     results_checked, pending_matches[0], match);
                    end
                    void'(pending_matches.pop_front());
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (request_q.size() >= CALM_TAIL && tick[7:6] != 2'b01 &&
                     $urandom_range(0, 7) == 0)
            begin
                stall_left = int'($urandom_range(0, 17));
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        foreach (pat_tally[b])
            pat_tally[b] = 0;
        pat_len = 0;
        restart_text();
        build_stimulus();
        total_requests = request_q.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every request to be taken and every match to come back.
        while (requests_taken < total_requests)
            @(negedge clk);
        while (pending_matches.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        $display("Sent %0d requests (random patterns and texts, clears, noise).",
                 requests_taken);
        $display("Checked %0d text results, %0d of them matches; %0d errors.",
                 results_checked, matches_seen, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/wanm_pkg.sv
rtl/window_anagram_near_match.sv
dv/window_anagram_near_match_tb.sv
